/* design/rtdfa_pkg.sv */
// Package for the range transition DFA engine: action, status and sequencer codes.
// No dependencies; imported by the top level and the checker.
`default_nettype none

package rtdfa_pkg;

    localparam logic [6:0] NO_DEFAULT = 7'h7F;

    typedef enum logic [2:0] {
        ACT_STEP      = 3'd0,
        ACT_ADD_STATE = 3'd1,
        ACT_ADD_RANGE = 3'd2,
        ACT_SET_DFLT  = 3'd3,
        ACT_RESTART   = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        STAT_OK         = 3'd0,
        STAT_BAD_ORDER  = 3'd1,
        STAT_TRANS_FULL = 3'd2,
        STAT_UNKNOWN    = 3'd3,
        STAT_DFLT_SET   = 3'd4,
        STAT_EMPTY      = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_FETCH,
        FSM_EXEC,
        FSM_SCAN,
        FSM_FINAL,
        FSM_DONE
    } fsm_t;

endpackage

`default_nettype wire

/* design/rtdfa_in_if.sv */
// Input channel of the DFA engine: valid/ready handshake and one action beat.
// No dependencies.
`default_nettype none

interface rtdfa_in_if;
    logic              valid;
    logic              ready;
    logic [2:0]        action;
    logic [5:0]        state_index;
    logic [5:0]        next_state;
    logic signed [7:0] char_low;
    logic signed [7:0] char_high;
    logic              is_final;
    logic signed [7:0] symbol;

    modport source (output valid, action, state_index, next_state, char_low, char_high,
                    is_final, symbol, input ready);
    modport sink (input valid, action, state_index, next_state, char_low, char_high,
                  is_final, symbol, output ready);
endinterface

`default_nettype wire

/* design/rtdfa_out_if.sv */
// Result channel of the DFA engine: valid/ready handshake and one result beat.
// No dependencies.
`default_nettype none

interface rtdfa_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] current_state;
    logic       accepting;
    logic       dead;
    logic [2:0] status;

    modport source (output valid, current_state, accepting, dead, status, input ready);
    modport sink (input valid, current_state, accepting, dead, status, output ready);
endinterface

`default_nettype wire

/* design/range_transition_dfa_engine_unit.sv */
// Range transition DFA engine: state and range tables in memories, one range comparator
// stepped over the stored ranges by a small sequencer. Uses rtdfa_pkg and both channel ifs.
// Each action runs fetch, exec, an optional scan over the stored ranges of the current state
// (up to RANGE_CAP; none for build, restart and unused actions), final and done; one action
// is in flight at a time, and a stalled result holds the sequencer and input ready stays low.
// Reset clears sequencer, current state, dead flag and state count; memories are not cleared.
`default_nettype none

module range_transition_dfa_engine_unit
    import rtdfa_pkg::*;
#(
    parameter int STATE_CAP = 64,
    parameter int RANGE_CAP = 16
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    rtdfa_in_if.sink    req,
    rtdfa_out_if.source rsp
);

    localparam int SAW = $clog2(STATE_CAP);
    localparam int SAC = $clog2(STATE_CAP + 1);
    localparam int CW  = $clog2(RANGE_CAP + 1);
    localparam int RD  = STATE_CAP * RANGE_CAP;
    localparam int RAW = $clog2(RD);
    localparam int SWW = 1 + 7 + CW;
    localparam int RWW = 8 + 8 + 6;

    function automatic logic [SAW-1:0] st_addr(input logic [5:0] s);
        st_addr = SAW'(s);
    endfunction

    function automatic logic [RAW-1:0] rng_addr(input logic [5:0] s, input logic [CW-1:0] slot);
        rng_addr = RAW'(32'(st_addr(s)) * RANGE_CAP + 32'(slot));
    endfunction

    fsm_t fsm_reg, fsm_next;

    logic [2:0]        act_reg;
    logic [5:0]        sidx_reg;
    logic [5:0]        nidx_reg;
    logic signed [7:0] lo_reg;
    logic signed [7:0] hi_reg;
    logic              fin_reg;
    logic signed [7:0] sym_reg;

    logic [5:0]     cur_reg, cur_next;
    logic           dead_reg, dead_next;
    logic [SAC-1:0] sa_reg, sa_next;
    status_t        status_reg, status_next;
    logic [CW-1:0]  scan_idx_reg, scan_idx_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [6:0]     dflt_reg, dflt_next;
    logic [RAW-1:0] raddr_reg, raddr_next;

    logic       rsp_valid_reg, rsp_valid_next;
    logic [5:0] rsp_state_reg;
    logic       rsp_acc_reg;
    logic       rsp_dead_reg;
    status_t    rsp_status_reg;

    logic [SWW-1:0] st_mem [STATE_CAP];
    logic [SWW-1:0] st_rdata_reg;
    logic [SAW-1:0] st_raddr;
    logic           st_we;
    logic [SAW-1:0] st_waddr;
    logic [SWW-1:0] st_wdata;

    logic [RWW-1:0] rng_mem [RD];
    logic [RWW-1:0] rng_rdata_reg;
    logic           rng_we;
    logic [RAW-1:0] rng_waddr;
    logic [RWW-1:0] rng_wdata;

    logic           req_beat;
    logic           load_rsp;
    logic           st_fin;
    logic [6:0]     st_dflt;
    logic [CW-1:0]  st_cnt;
    logic signed [7:0] r_lo;
    logic signed [7:0] r_hi;
    logic [5:0]     r_tgt;
    logic           r_match;
    logic           exec_scan;
    logic           scan_last;
    logic [6:0]     tgt;
    logic           apply;
    logic           unknown;

    assign req_beat = req.valid && req.ready;
    assign load_rsp = (fsm_reg == FSM_DONE) && (!rsp_valid_reg || rsp.ready);

    assign st_fin  = st_rdata_reg[SWW-1];
    assign st_dflt = st_rdata_reg[CW+6:CW];
    assign st_cnt  = st_rdata_reg[CW-1:0];
    assign r_lo    = rng_rdata_reg[21:14];
    assign r_hi    = rng_rdata_reg[13:6];
    assign r_tgt   = rng_rdata_reg[5:0];
    assign r_match = (sym_reg >= r_lo) && (sym_reg <= r_hi);
    assign unknown = (32'(sidx_reg) >= 32'(sa_reg)) || (32'(nidx_reg) >= 32'(sa_reg));
    assign exec_scan = (act_reg == ACT_STEP) && (sa_reg != '0) && !dead_reg
                       && (32'(cur_reg) < 32'(sa_reg)) && (st_cnt != '0);
    assign scan_last = r_match || (scan_idx_reg + CW'(1) == cnt_reg);

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            st_mem[st_waddr] <= st_wdata;
        end
        st_rdata_reg <= st_mem[st_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (rng_we)
        begin
            rng_mem[rng_waddr] <= rng_wdata;
        end
        rng_rdata_reg <= rng_mem[raddr_next];
    end

    always_comb
    begin
        fsm_next = fsm_reg;
        unique case (fsm_reg)
            FSM_IDLE:  if (req_beat) fsm_next = FSM_FETCH;
            FSM_FETCH: fsm_next = FSM_EXEC;
            FSM_EXEC:  fsm_next = exec_scan ? FSM_SCAN : FSM_FINAL;
            FSM_SCAN:  if (scan_last) fsm_next = FSM_FINAL;
            FSM_FINAL: fsm_next = FSM_DONE;
            FSM_DONE:  if (load_rsp) fsm_next = FSM_IDLE;
            default:   fsm_next = FSM_IDLE;
        endcase
    end

    always_comb
    begin
        cur_next      = cur_reg;
        dead_next     = dead_reg;
        sa_next       = sa_reg;
        status_next   = status_reg;
        scan_idx_next = scan_idx_reg;
        cnt_next      = cnt_reg;
        dflt_next     = dflt_reg;
        raddr_next    = raddr_reg;
        st_raddr      = st_addr(cur_reg);
        st_we         = 1'b0;
        st_waddr      = st_addr(sidx_reg);
        st_wdata      = {st_fin, st_dflt, st_cnt};
        rng_we        = 1'b0;
        rng_waddr     = rng_addr(sidx_reg, st_cnt);
        rng_wdata     = {lo_reg, hi_reg, nidx_reg};
        tgt           = NO_DEFAULT;
        apply         = 1'b0;

        unique case (fsm_reg)
            FSM_FETCH:
            begin
                st_raddr    = (act_reg == ACT_STEP) ? st_addr(cur_reg) : st_addr(sidx_reg);
                status_next = STAT_OK;
            end
            FSM_EXEC:
            begin
                unique case (act_reg)
                    ACT_STEP:
                    begin
                        cnt_next      = st_cnt;
                        dflt_next     = st_dflt;
                        scan_idx_next = '0;
                        raddr_next    = rng_addr(cur_reg, '0);
                        if (sa_reg == '0)
                        begin
                            status_next = STAT_EMPTY;
                        end
                        else if (!dead_reg && (32'(cur_reg) < 32'(sa_reg)) && (st_cnt == '0))
                        begin
                            tgt   = st_dflt;
                            apply = 1'b1;
                        end
                    end
                    ACT_ADD_STATE:
                    begin
                        if ((32'(sidx_reg) != 32'(sa_reg)) || (32'(sa_reg) >= STATE_CAP))
                        begin
                            status_next = STAT_BAD_ORDER;
                        end
                        else
                        begin
                            st_we    = 1'b1;
                            st_wdata = {fin_reg, NO_DEFAULT, CW'(0)};
                            sa_next  = sa_reg + SAC'(1);
                        end
                    end
                    ACT_ADD_RANGE:
                    begin
                        if (unknown)
                        begin
                            status_next = STAT_UNKNOWN;
                        end
                        else if (32'(st_cnt) >= RANGE_CAP)
                        begin
                            status_next = STAT_TRANS_FULL;
                        end
                        else
                        begin
                            rng_we   = 1'b1;
                            st_we    = 1'b1;
                            st_wdata = {st_fin, st_dflt, st_cnt + CW'(1)};
                        end
                    end
                    ACT_SET_DFLT:
                    begin
                        if (unknown)
                        begin
                            status_next = STAT_UNKNOWN;
                        end
                        else if (st_dflt != NO_DEFAULT)
                        begin
                            status_next = STAT_DFLT_SET;
                        end
                        else
                        begin
                            st_we    = 1'b1;
                            st_wdata = {st_fin, 1'b0, nidx_reg, st_cnt};
                        end
                    end
                    ACT_RESTART:
                    begin
                        cur_next  = '0;
                        dead_next = 1'b0;
                        if (sa_reg == '0)
                        begin
                            status_next = STAT_EMPTY;
                        end
                    end
                    default:
                    begin
                        status_next = STAT_OK;
                    end
                endcase
            end
            FSM_SCAN:
            begin
                if (r_match)
                begin
                    tgt   = {1'b0, r_tgt};
                    apply = 1'b1;
                end
                else if (scan_last)
                begin
                    tgt   = dflt_reg;
                    apply = 1'b1;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + CW'(1);
                    raddr_next    = raddr_reg + RAW'(1);
                end
            end
            default:
            begin
                st_raddr = st_addr(cur_reg);
            end
        endcase

        if (apply)
        begin
            if ((tgt == NO_DEFAULT) || (32'(tgt) >= 32'(sa_reg)))
            begin
                dead_next = 1'b1;
            end
            else
            begin
                cur_next = tgt[5:0];
            end
        end
    end

    always_comb
    begin
        req.ready         = (fsm_reg == FSM_IDLE);
        rsp.valid         = rsp_valid_reg;
        rsp.current_state = rsp_state_reg;
        rsp.accepting     = rsp_acc_reg;
        rsp.dead          = rsp_dead_reg;
        rsp.status        = rsp_status_reg;
        rsp_valid_next    = rsp_valid_reg && !rsp.ready;
        if (load_rsp)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg       <= FSM_IDLE;
            cur_reg       <= '0;
            dead_reg      <= 1'b0;
            sa_reg        <= '0;
            status_reg    <= STAT_OK;
            scan_idx_reg  <= '0;
            cnt_reg       <= '0;
            raddr_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            fsm_reg       <= fsm_next;
            cur_reg       <= cur_next;
            dead_reg      <= dead_next;
            sa_reg        <= sa_next;
            status_reg    <= status_next;
            scan_idx_reg  <= scan_idx_next;
            cnt_reg       <= cnt_next;
            raddr_reg     <= raddr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dflt_reg <= dflt_next;
        if (req_beat)
        begin
            act_reg  <= req.action;
            sidx_reg <= req.state_index;
            nidx_reg <= req.next_state;
            lo_reg   <= req.char_low;
            hi_reg   <= req.char_high;
            fin_reg  <= req.is_final;
            sym_reg  <= req.symbol;
        end
        if (load_rsp)
        begin
            rsp_state_reg  <= cur_reg;
            rsp_acc_reg    <= (32'(cur_reg) < 32'(sa_reg)) && !dead_reg && st_fin;
            rsp_dead_reg   <= dead_reg;
            rsp_status_reg <= status_reg;
        end
    end

endmodule

`default_nettype wire

/* design/rtdfa_chk.sv */
// Port-level checker for the DFA engine, bound to the top level below.
// Depends on rtdfa_pkg and range_transition_dfa_engine_unit.
`default_nettype none

module rtdfa_chk
    import rtdfa_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       req_valid,
    input wire logic       req_ready,
    input wire logic       rsp_valid,
    input wire logic       rsp_ready,
    input wire logic [5:0] rsp_state,
    input wire logic       rsp_acc,
    input wire logic       rsp_dead,
    input wire logic [2:0] rsp_status
);

    // one action in flight: ready drops after every accepted beat
    a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("ready stayed high after an accepted beat");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid
            && $stable(rsp_state) && $stable(rsp_acc) && $stable(rsp_dead)
            && $stable(rsp_status))
        else $error("stalled result beat changed");

    a_acc_not_dead: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp_acc && rsp_dead))
        else $error("accepting while dead");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_status <= STAT_EMPTY))
        else $error("status code out of range");

endmodule

bind range_transition_dfa_engine_unit rtdfa_chk u_rtdfa_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_state  (rsp.current_state),
    .rsp_acc    (rsp.accepting),
    .rsp_dead   (rsp.dead),
    .rsp_status (rsp.status)
);

`default_nettype wire

/* sim/rtdfa_checker.sv */
`timescale 1ns / 1ps
// Checker for the range transition DFA engine: watches both channels, keeps its own
// copy of the state and range tables, and compares every result beat field by field.
// Depends on rtdfa_pkg, rtdfa_in_if and rtdfa_out_if.

module rtdfa_checker
    import rtdfa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    rtdfa_in_if        req,
    rtdfa_out_if       rsp,
    output int         errors,
    output int         outstanding,
    output int         checked,
    output logic [7:0] status_seen
);

    localparam int DFA_STATES = 64;
    localparam int DFA_RANGES = 16;

    typedef struct {
        logic [5:0] state;
        logic       accepting;
        logic       dead;
        status_t    status;
    } dfa_result_t;

    logic [5:0]        cur_state;
    logic              dead_q;
    int                built;
    int                range_count [DFA_STATES];
    logic signed [7:0] range_lo [DFA_STATES * DFA_RANGES];
    logic signed [7:0] range_hi [DFA_STATES * DFA_RANGES];
    logic [5:0]        range_to [DFA_STATES * DFA_RANGES];
    logic [6:0]        default_to [DFA_STATES];
    logic              final_q [DFA_STATES];

    dfa_result_t expected_results [$];
    int          err_count = 0;
    int          beat_count = 0;
    logic [7:0]  seen_mask = '0;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t result %0d: %s", $time, beat_count, msg);
        err_count++;
    endtask

    function automatic dfa_result_t advance_dfa(
        input logic [2:0]        act,
        input logic [5:0]        sidx,
        input logic [5:0]        nidx,
        input logic signed [7:0] lo,
        input logic signed [7:0] hi,
        input logic              fin,
        input logic signed [7:0] sym
    );
        dfa_result_t res;
        status_t     st;
        int          target;
        int          base;
        int          slot;
        logic        hit;
        st = STAT_OK;
        case (act)
            ACT_STEP:
            begin
                if (built == 0)
                begin
                    st = STAT_EMPTY;
                end
                else if (!dead_q && int'(cur_state) < built)
                begin
                    target = int'(NO_DEFAULT);
                    hit = 1'b0;
                    base = int'(cur_state) * DFA_RANGES;
                    for (int i = 0; i < range_count[cur_state]; i++)
                    begin
                        if (!hit && sym >= range_lo[base + i] && sym <= range_hi[base + i])
                        begin
                            hit = 1'b1;
                            target = int'(range_to[base + i]);
                        end
                    end
                    if (!hit)
                        target = int'(default_to[cur_state]);
                    if (target == int'(NO_DEFAULT) || target >= built)
                        dead_q = 1'b1;
                    else
                        cur_state = 6'(target);
                end
            end
            ACT_ADD_STATE:
            begin
                if (int'(sidx) != built || built >= DFA_STATES)
                begin
                    st = STAT_BAD_ORDER;
                end
                else
                begin
                    final_q[sidx] = fin;
                    range_count[sidx] = 0;
                    default_to[sidx] = NO_DEFAULT;
                    built++;
                end
            end
            ACT_ADD_RANGE:
            begin
                if (int'(sidx) >= built || int'(nidx) >= built)
                begin
                    st = STAT_UNKNOWN;
                end
                else if (range_count[sidx] >= DFA_RANGES)
                begin
                    st = STAT_TRANS_FULL;
                end
                else
                begin
                    slot = int'(sidx) * DFA_RANGES + range_count[sidx];
                    range_lo[slot] = lo;
                    range_hi[slot] = hi;
                    range_to[slot] = nidx;
                    range_count[sidx]++;
                end
            end
            ACT_SET_DFLT:
            begin
                if (int'(sidx) >= built || int'(nidx) >= built)
                    st = STAT_UNKNOWN;
                else if (default_to[sidx] != NO_DEFAULT)
                    st = STAT_DFLT_SET;
                else
                    default_to[sidx] = {1'b0, nidx};
            end
            ACT_RESTART:
            begin
                cur_state = '0;
                dead_q = 1'b0;
                if (built == 0)
                    st = STAT_EMPTY;
            end
            default:
            begin
            end
        endcase
        res.state = cur_state;
        res.accepting = (int'(cur_state) < built) && !dead_q && final_q[cur_state];
        res.dead = dead_q;
        res.status = st;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        dfa_result_t want;
        if (!rst_n)
        begin
            cur_state = '0;
            dead_q = 1'b0;
            built = 0;
            expected_results.delete();
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("result beat with nothing outstanding");
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (rsp.current_state !== want.state)
                        report_mismatch($sformatf("current_state got %0d, want %0d",
                                                  rsp.current_state, want.state));
                    if (rsp.accepting !== want.accepting)
                        report_mismatch($sformatf("accepting got %b, want %b",
                                                  rsp.accepting, want.accepting));
                    if (rsp.dead !== want.dead)
                        report_mismatch($sformatf("dead got %b, want %b",
                                                  rsp.dead, want.dead));
                    if (rsp.status !== want.status)
                        report_mismatch($sformatf("status got %0d, want %s",
                                                  rsp.status, want.status.name()));
                    beat_count++;
                end
            end
            if (req.valid && req.ready)
            begin
                want = advance_dfa(req.action, req.state_index, req.next_state, req.char_low,
                                   req.char_high, req.is_final, req.symbol);
                seen_mask[want.status] = 1'b1;
                expected_results.push_back(want);
            end
        end
        errors <= err_count;
        outstanding <= expected_results.size();
        checked <= beat_count;
        status_seen <= seen_mask;
    end

endmodule

/* sim/tb_range_transition_dfa_engine_unit.sv */
`timescale 1ns / 1ps
// Testbench top for the range transition DFA engine: clock, reset, action stimulus,
// result back-pressure and verdict. Depends on rtdfa_pkg, both channel interfaces,
// range_transition_dfa_engine_unit and rtdfa_checker.

module tb_range_transition_dfa_engine_unit
    import rtdfa_pkg::*;
();

    localparam logic [2:0] ACT_RESERVED_FIRST = 3'd5;
    localparam logic [2:0] ACT_RESERVED_LAST  = 3'd7;
    localparam int         TABLE_STATES       = 64;
    localparam int         PHASE_ITEMS        = 150;
    localparam int         DRAIN_CYCLES       = 40;
    localparam int         CYCLE_LIMIT        = 400000;

    typedef struct {
        logic [2:0]        act;
        logic [5:0]        sidx;
        logic [5:0]        nidx;
        logic signed [7:0] lo;
        logic signed [7:0] hi;
        logic              fin;
        logic signed [7:0] sym;
    } dfa_cmd_t;

    logic       clk;
    logic       rst_n;
    int         errors;
    int         outstanding;
    int         checked;
    logic [7:0] status_seen;
    int         src_idle_pct;
    int         sink_idle_pct;
    int         n_states;
    int         items_sent;
    int         directed_items;
    int         cycle_count = 0;

    rtdfa_in_if  req_ch ();
    rtdfa_out_if rsp_ch ();

    range_transition_dfa_engine_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    rtdfa_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .errors      (errors),
        .outstanding (outstanding),
        .checked     (checked),
        .status_seen (status_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
                     outstanding);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
            rsp_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    function automatic dfa_cmd_t mk(input logic [2:0] act, input int sidx, input int nidx,
                                    input int lo, input int hi, input int fin, input int sym);
        dfa_cmd_t c;
        c.act = act;
        c.sidx = 6'(sidx);
        c.nidx = 6'(nidx);
        c.lo = 8'(lo);
        c.hi = 8'(hi);
        c.fin = 1'(fin);
        c.sym = 8'(sym);
        return c;
    endfunction

    // biased toward states 0 and 1 so their range tables fill up
    function automatic logic [5:0] pick_state(input int built);
        int r;
        r = $urandom_range(0, 99);
        if (built == 0 || r < 15)
            return 6'($urandom_range(0, 63));
        else if (r < 40)
            return 6'($urandom_range(0, (built > 1) ? 1 : 0));
        else
            return 6'($urandom_range(0, built - 1));
    endfunction

    function automatic dfa_cmd_t random_cmd(input int built);
        dfa_cmd_t    c;
        logic [31:0] r;
        int          pick;
        int          hi_i;
        r = $urandom;
        c.sidx = r[5:0];
        c.nidx = r[11:6];
        c.lo = r[19:12];
        c.hi = r[27:20];
        c.fin = r[28];
        r = $urandom;
        c.sym = r[7:0];
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            c.act = ACT_STEP;
        end
        else if (pick < 62)
        begin
            c.act = ACT_ADD_RANGE;
            c.sidx = pick_state(built);
            c.nidx = pick_state(built);
            if ($urandom_range(0, 9) != 0)
            begin
                hi_i = int'(c.lo) + $urandom_range(0, 40);
                if (hi_i > 127)
                    hi_i = 127;
                c.hi = 8'(hi_i);
            end
        end
        else if (pick < 82)
        begin
            c.act = ACT_ADD_STATE;
            if (built < TABLE_STATES && $urandom_range(0, 99) < 85)
                c.sidx = 6'(built);
        end
        else if (pick < 89)
        begin
            c.act = ACT_SET_DFLT;
            c.sidx = pick_state(built);
            c.nidx = pick_state(built);
        end
        else if (pick < 95)
        begin
            c.act = ACT_RESTART;
        end
        else
        begin
            c.act = 3'($urandom_range(ACT_RESERVED_FIRST, ACT_RESERVED_LAST));
        end
        return c;
    endfunction

    task automatic send(input dfa_cmd_t c);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.action <= c.act;
        req_ch.state_index <= c.sidx;
        req_ch.next_state <= c.nidx;
        req_ch.char_low <= c.lo;
        req_ch.char_high <= c.hi;
        req_ch.is_final <= c.fin;
        req_ch.symbol <= c.sym;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        if (c.act == ACT_ADD_STATE && int'(c.sidx) == n_states && n_states < TABLE_STATES)
            n_states++;
        items_sent++;
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic run_random(input int count, input int src_pct, input int sink_pct);
        src_idle_pct = src_pct;
        sink_idle_pct = sink_pct;
        repeat (count)
            send(random_cmd(n_states));
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.action = ACT_STEP;
        req_ch.state_index = '0;
        req_ch.next_state = '0;
        req_ch.char_low = '0;
        req_ch.char_high = '0;
        req_ch.is_final = 1'b0;
        req_ch.symbol = '0;
        src_idle_pct = 15;
        sink_idle_pct = 81;
        n_states = 0;
        items_sent = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty machine
        send(mk(ACT_STEP, 0, 0, 0, 0, 0, 127));
        send(mk(ACT_RESTART, 0, 0, 0, 0, 0, 0));
        send(mk(ACT_ADD_RANGE, 0, 0, -128, 127, 0, 0));
        send(mk(ACT_SET_DFLT, 0, 0, 0, 0, 0, 0));
        for (int a = ACT_RESERVED_FIRST; a <= ACT_RESERVED_LAST; a++)
            send(mk(3'(a), 63, 63, -1, -1, 1, -1));
        // build three states
        send(mk(ACT_ADD_STATE, 1, 0, 0, 0, 1, 0));
        send(mk(ACT_ADD_STATE, 0, 0, 0, 0, 0, 0));
        send(mk(ACT_ADD_STATE, 1, 0, 0, 0, 1, 0));
        send(mk(ACT_ADD_STATE, 2, 0, 0, 0, 1, 0));
        send(mk(ACT_ADD_RANGE, 0, 1, -128, -1, 0, 0));
        send(mk(ACT_ADD_RANGE, 0, 2, 127, 127, 0, 0));
        send(mk(ACT_ADD_RANGE, 0, 1, 10, 5, 0, 0));
        send(mk(ACT_ADD_RANGE, 63, 0, 0, 0, 0, 0));
        send(mk(ACT_ADD_RANGE, 0, 63, 0, 0, 0, 0));
        send(mk(ACT_SET_DFLT, 1, 0, 0, 0, 0, 0));
        send(mk(ACT_SET_DFLT, 1, 2, 0, 0, 0, 0));
        // walk: into 1, back via default, dead on no match, restart
        send(mk(ACT_STEP, 0, 0, 0, 0, 0, -128));
        send(mk(ACT_STEP, 0, 0, 0, 0, 0, 0));
        send(mk(ACT_STEP, 0, 0, 0, 0, 0, 7));
        send(mk(ACT_STEP, 0, 0, 0, 0, 0, -1));
        send(mk(ACT_RESTART, 0, 0, 0, 0, 0, 0));
        send(mk(ACT_STEP, 0, 0, 0, 0, 0, 127));
        send(mk(ACT_STEP, 0, 0, 0, 0, 0, 0));
        send(mk(ACT_RESTART, 0, 0, 0, 0, 0, 0));
        directed_items = items_sent;

        run_random(PHASE_ITEMS, 15, 81);
        wait_drained();
        run_random(PHASE_ITEMS, 81, 15);
        run_random(PHASE_ITEMS, 0, 0);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d action beats (%0d directed) under three idle mixes, %0d checked",
                 items_sent, directed_items, checked);
        $display("Table grew to %0d states; status codes seen (bit per code): %b",
                 n_states, status_seen);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
